// ===== hw/rtl/slpm_pkg.sv =====
// Shared types, constants and codes of the slotted page record manager.
package slpm_pkg;

   localparam int PAGE_BYTES   = 4096;
   localparam int HEADER_BYTES = 16;
   localparam int SLOT_BYTES   = 4;
   localparam int MAX_SLOTS    = 1024;

   localparam int ACT_W  = 3;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int OFF_W  = 13;
   localparam int PAGE_W = 32;
   localparam int STAT_W = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // action codes
   localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_GET    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STAT_W-1:0] ST_DELETED = 2'd3;

   typedef enum logic [2:0] {
      KIND_INSERT = 3'd0,
      KIND_DELETE = 3'd1,
      KIND_UPDATE = 3'd2,
      KIND_GET    = 3'd3,
      KIND_CLEAR  = 3'd4,
      KIND_NOP    = 3'd5
   } kind_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [IDX_W-1:0] slot_index;
      logic [OFF_W-1:0] record_size;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PAGE_W-1:0] result_page;
      logic [IDX_W-1:0]  result_slot;
      logic [OFF_W-1:0]  record_offset;
      logic [OFF_W-1:0]  record_length;
      logic [IDX_W-1:0]  records_used;
      logic [OFF_W-1:0]  free_bytes;
   } rsp_type;

   // classified work item carried from front to back
   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] slot_index;
      logic [OFF_W-1:0] record_size;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic [OFF_W-1:0] offset;
      logic [OFF_W-1:0] size;
   } entry_type;

endpackage

// ===== hw/rtl/slpm_queue.sv =====
// Two-entry work queue between the front and back sections.
module slpm_queue
   import slpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  item_type     push_item,
   input  logic         pop,
   output item_type     head_item,
   output q_status_type q_status
);

   item_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> !pop)
      else $error("queue underflow");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count lost a push");

endmodule

// ===== hw/rtl/slpm_front.sv =====
// Front section: takes transactions, decodes the action, feeds the queue.
module slpm_front
   import slpm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_payload,
   input  q_status_type q_status,
   output logic         push,
   output item_type     push_item
);

   logic     stage_valid_ff, stage_valid_in;
   item_type stage_item_ff;
   item_type decoded;
   logic     accept;

   always_comb begin
      decoded.slot_index  = req_payload.slot_index;
      decoded.record_size = req_payload.record_size;
      unique case (req_payload.action)
         ACT_INSERT: decoded.kind = KIND_INSERT;
         ACT_DELETE: decoded.kind = KIND_DELETE;
         ACT_UPDATE: decoded.kind = KIND_UPDATE;
         ACT_GET:    decoded.kind = KIND_GET;
         ACT_CLEAR:  decoded.kind = KIND_CLEAR;
         default:    decoded.kind = KIND_NOP;
      endcase
   end

   assign push           = stage_valid_ff && !q_status.full;
   assign busy           = stage_valid_ff && q_status.full;
   assign accept         = start && !busy;
   assign stage_valid_in = accept || (stage_valid_ff && !push);
   assign push_item      = stage_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_item_ff <= decoded;
      end
   end

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      busy |=> stage_valid_ff && $stable(stage_item_ff))
      else $error("front stage lost a held transaction");
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> stage_valid_ff)
      else $error("accepted transaction not staged");
   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> q_status.full)
      else $error("busy without a full queue");

endmodule

// ===== hw/rtl/slpm_back.sv =====
// Back section: slot directory memory, page pointers and result register.
module slpm_back
   import slpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [PAGE_W-1:0] page_number,
   input  q_status_type      q_status,
   input  item_type          head_item,
   output logic              pop,
   output logic              rsp_strobe,
   output rsp_type           rsp_payload
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   item_type          cur_ff;
   entry_type         mem [MAX_SLOTS];
   entry_type         rd_data_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   entry_type         wr_data;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [OFF_W-1:0]  fp_ff, fp_in;
   logic [OFF_W-1:0]  free_ff, free_in;

   logic              rsp_strobe_ff;
   rsp_type           rsp_payload_ff;
   rsp_type           result;

   logic [OFF_W:0]    size_ext;
   logic [OFF_W:0]    free_ext;
   logic [OFF_W:0]    ins_need;
   logic [OFF_W-1:0]  new_off;
   logic              in_range;

   assign pop = (state_ff == ST_IDLE) && !q_status.empty;

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = pop ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign size_ext = {1'b0, cur_ff.record_size};
   assign free_ext = {1'b0, free_ff};
   assign ins_need = size_ext + (OFF_W+1)'(SLOT_BYTES);
   assign new_off  = fp_ff - cur_ff.record_size;
   assign in_range = {1'b0, cur_ff.slot_index} < count_ff;

   always_comb begin
      wr_en                = 1'b0;
      wr_addr              = cur_ff.slot_index;
      wr_data              = rd_data_ff;
      count_in             = count_ff;
      fp_in                = fp_ff;
      free_in              = free_ff;
      result.status        = ST_OK;
      result.result_page   = page_number;
      result.result_slot   = '0;
      result.record_offset = '0;
      result.record_length = '0;
      if (state_ff == ST_EXEC) begin
         case (cur_ff.kind)
            KIND_INSERT: begin
               if ((count_ff < CNT_W'(MAX_SLOTS)) && (ins_need <= free_ext)) begin
                  wr_en                = 1'b1;
                  wr_addr              = count_ff[IDX_W-1:0];
                  wr_data.offset       = new_off;
                  wr_data.size         = cur_ff.record_size;
                  count_in             = count_ff + CNT_W'(1);
                  fp_in                = new_off;
                  free_in              = OFF_W'(free_ext - ins_need);
                  result.result_slot   = count_ff[IDX_W-1:0];
                  result.record_offset = new_off;
                  result.record_length = cur_ff.record_size;
               end else begin
                  result.status = ST_NOSPACE;
               end
            end
            KIND_DELETE, KIND_UPDATE, KIND_GET: begin
               result.result_slot = cur_ff.slot_index;
               if (!in_range) begin
                  result.status = ST_RANGE;
               end else if (rd_data_ff.size == '0) begin
                  result.status = ST_DELETED;
               end else if (cur_ff.kind == KIND_DELETE) begin
                  wr_en                = 1'b1;
                  wr_data.size         = '0;
                  result.record_offset = rd_data_ff.offset;
               end else if (cur_ff.kind == KIND_GET) begin
                  result.record_offset = rd_data_ff.offset;
                  result.record_length = rd_data_ff.size;
               end else if (cur_ff.record_size <= rd_data_ff.size) begin
                  // shrink in place
                  wr_en                = 1'b1;
                  wr_data.size         = cur_ff.record_size;
                  result.record_offset = rd_data_ff.offset;
                  result.record_length = cur_ff.record_size;
               end else if (size_ext <= free_ext) begin
                  // grow: move to fresh space
                  wr_en                = 1'b1;
                  wr_data.offset       = new_off;
                  wr_data.size         = cur_ff.record_size;
                  fp_in                = new_off;
                  free_in              = free_ff - cur_ff.record_size;
                  result.record_offset = new_off;
                  result.record_length = cur_ff.record_size;
               end else begin
                  result.status = ST_NOSPACE;
               end
            end
            KIND_CLEAR: begin
               count_in = '0;
               fp_in    = OFF_W'(PAGE_BYTES);
               free_in  = OFF_W'(PAGE_BYTES - HEADER_BYTES);
            end
            default: begin
            end
         endcase
      end
      result.records_used = count_in[IDX_W-1:0];
      result.free_bytes   = free_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         fp_ff         <= OFF_W'(PAGE_BYTES);
         free_ff       <= OFF_W'(PAGE_BYTES - HEADER_BYTES);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         fp_ff         <= fp_in;
         free_ff       <= free_in;
         rsp_strobe_ff <= (state_ff == ST_EXEC);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head_item;
      end
      if (state_ff == ST_EXEC) begin
         rsp_payload_ff <= result;
      end
   end

   // slot directory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[head_item.slot_index];
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == ST_EXEC))
      else $error("result strobe without an executed transaction");
   a_space_invariant: assert property (@(posedge clock) disable iff (reset)
      (16'(free_ff) + 16'(HEADER_BYTES) + 16'(count_ff) * 16'(SLOT_BYTES))
         == 16'(fp_ff))
      else $error("free byte count out of step with pointers");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SLOTS))
      else $error("slot count above directory size");
   a_one_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (state_ff == ST_IDLE))
      else $error("execute state held");

endmodule

// ===== hw/rtl/slotted_page_record_manager.sv =====
// Top level of the slotted page record manager.
//
// Keeps the slot directory (offset and size per slot) and the free-space
// pointer of one page. A transaction is taken on a clock edge where start is
// high and busy is low; every transaction gives exactly one result, shown on
// rsp_payload for one cycle while rsp_strobe is high. The receiver cannot
// stall results. Results come out in the order transactions were taken.
// The back section takes a new transaction only once the last is done: it
// reads the slot entry from the directory RAM (registered read) on leaving
// the idle state, then updates it and writes it back in the execute state.
// The front stage and the two-entry queue absorb bursts; busy rises once both
// are full. There is no clearing pass: the directory needs none, since only
// entries of slots below the slot count are ever used. csr_write_data is
// taken into page_number on any edge with csr_write_en high; write it only
// while no transaction is in flight.
module slotted_page_record_manager
   import slpm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_payload,
   output logic              rsp_strobe,
   output rsp_type           rsp_payload,
   input  logic              csr_write_en,
   input  logic [PAGE_W-1:0] csr_write_data
);

   logic [PAGE_W-1:0] page_number_ff;
   q_status_type      q_status;
   logic              push;
   item_type          push_item;
   logic              pop;
   item_type          head_item;

   // page identifier register
   always_ff @(posedge clock) begin
      if (reset) begin
         page_number_ff <= '0;
      end else if (csr_write_en) begin
         page_number_ff <= csr_write_data;
      end
   end

   // decode and stage incoming transactions
   slpm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   // decouples the front from the directory update
   slpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   // directory RAM, pointers, result register
   slpm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .page_number (page_number_ff),
      .q_status    (q_status),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== bench/slotted_page_record_manager_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the slotted page record manager: directed and random transactions.
import slpm_pkg::*;

// Tracks the page's slot directory and free pointer, predicts each result
// and compares it with what the block returns.
class slot_directory_checker;
   logic [OFF_W-1:0]  rec_offset [MAX_SLOTS];
   logic [OFF_W-1:0]  rec_size   [MAX_SLOTS];
   int                slots_used;
   int                free_ptr;
   logic [PAGE_W-1:0] page_id;
   int                errors;
   rsp_type           awaited[$];

   function new();
      slots_used = 0;
      free_ptr   = PAGE_BYTES;
      page_id    = '0;
      errors     = 0;
   endfunction

   // gap between directory end and free pointer, floored at zero
   function int free_left();
      int used;
      used = HEADER_BYTES + slots_used * SLOT_BYTES;
      return (free_ptr < used) ? 0 : free_ptr - used;
   endfunction

   function void note_request(req_type r);
      rsp_type e;
      int      idx;
      int      sz;
      idx = r.slot_index;
      sz  = r.record_size;
      e = '0;
      e.status = ST_OK;
      case (r.action)
         ACT_INSERT: begin
            if (slots_used < MAX_SLOTS && sz + SLOT_BYTES <= free_left()) begin
               free_ptr -= sz;
               rec_offset[slots_used] = OFF_W'(free_ptr);
               rec_size[slots_used]   = OFF_W'(sz);
               e.result_slot   = IDX_W'(slots_used);
               e.record_offset = OFF_W'(free_ptr);
               e.record_length = OFF_W'(sz);
               slots_used++;
            end else begin
               e.status = ST_NOSPACE;
            end
         end
         ACT_DELETE, ACT_UPDATE, ACT_GET: begin
            e.result_slot = r.slot_index;
            if (idx >= slots_used) begin
               e.status = ST_RANGE;
            end else if (rec_size[idx] == 0) begin
               e.status = ST_DELETED;
            end else if (r.action == ACT_DELETE) begin
               rec_size[idx]   = '0;
               e.record_offset = rec_offset[idx];
            end else if (r.action == ACT_GET) begin
               e.record_offset = rec_offset[idx];
               e.record_length = rec_size[idx];
            end else if (sz <= rec_size[idx]) begin
               // shrink in place; zero size turns it into a tombstone
               rec_size[idx]   = OFF_W'(sz);
               e.record_offset = rec_offset[idx];
               e.record_length = OFF_W'(sz);
            end else if (sz <= free_left()) begin
               // grow: move to fresh space below the free pointer
               free_ptr -= sz;
               rec_offset[idx] = OFF_W'(free_ptr);
               rec_size[idx]   = OFF_W'(sz);
               e.record_offset = OFF_W'(free_ptr);
               e.record_length = OFF_W'(sz);
            end else begin
               e.status = ST_NOSPACE;
            end
         end
         ACT_CLEAR: begin
            slots_used = 0;
            free_ptr   = PAGE_BYTES;
         end
         default: ;
      endcase
      e.result_page  = page_id;
      e.records_used = IDX_W'(slots_used);
      e.free_bytes   = OFF_W'(free_left());
      awaited.push_back(e);
   endfunction

   function void compare(string field, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, got_v);
         errors++;
      end
   endfunction

   function void check_result(rsp_type got);
      rsp_type e;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected result: expected none, got %h", $time, got);
         errors++;
         return;
      end
      e = awaited.pop_front();
      compare("status",        e.status,        got.status);
      compare("result_page",   e.result_page,   got.result_page);
      compare("result_slot",   e.result_slot,   got.result_slot);
      compare("record_offset", e.record_offset, got.record_offset);
      compare("record_length", e.record_length, got.record_length);
      compare("records_used",  e.records_used,  got.records_used);
      compare("free_bytes",    e.free_bytes,    got.free_bytes);
   endfunction
endclass

module slotted_page_record_manager_tb;

   // action codes the block treats as no-ops
   localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_payload;
   logic              rsp_strobe;
   rsp_type           rsp_payload;
   logic              csr_write_en;
   logic [PAGE_W-1:0] csr_write_data;

   slot_directory_checker directory = new();

   // sender pacing: percent chance of idling each cycle
   int sender_idle_pct;

   always #5 clock = ~clock;

   slotted_page_record_manager dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_strobe     (rsp_strobe),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Results cannot be held off: every strobed cycle is one transaction.
   // Values read here are the ones present before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         directory.check_result(rsp_payload);
      end
   end

   // Present one transaction and hold it until an edge sees busy low.
   // start is only ever assigned once per time step.
   task automatic issue(input logic [ACT_W-1:0] act, input int idx, input int sz);
      req_type r;
      r.action      = act;
      r.slot_index  = idx[IDX_W-1:0];
      r.record_size = sz[OFF_W-1:0];
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      directory.note_request(r);
   endtask

   // The page number is only written with nothing in flight; every
   // transaction yields a result, so an empty queue means the block is idle.
   task automatic write_page_number(input logic [PAGE_W-1:0] value);
      start <= 1'b0;
      while (directory.awaited.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en      <= 1'b0;
      directory.page_id  = value;
   endtask

   // One random transaction. Most target live slots so the update and
   // delete paths get exercised; the rest are inserts, clears, out-of-range and noise.
   // deep mode piles up tiny records to push the slot count past 512.
   task automatic random_item(input bit deep);
      int pick;
      int count;
      int idx;
      int old;
      int flavor;
      pick   = $urandom_range(99);
      flavor = $urandom_range(99);
      count  = directory.slots_used;
      idx    = (count > 0) ? $urandom_range(count - 1) : 0;
      old    = (count > 0) ? directory.rec_size[idx] : 0;
      if (deep) begin
         if (pick < 88) begin
            issue(ACT_INSERT, $urandom_range(1023), $urandom_range(2));
         end else if (pick < 94) begin
            issue(ACT_GET, idx, $urandom_range(4096));
         end else if (pick < 97) begin
            issue(ACT_UPDATE, idx, old + $urandom_range(2));
         end else begin
            issue(ACT_DELETE, idx, $urandom_range(4096));
         end
      end else if (pick < 38) begin
         if (flavor < 5) begin
            issue(ACT_INSERT, $urandom_range(1023), 0);
         end else if (flavor < 20) begin
            issue(ACT_INSERT, $urandom_range(1023), $urandom_range(4096));
         end else begin
            issue(ACT_INSERT, $urandom_range(1023), $urandom_range(64));
         end
      end else if (pick < 58) begin
         issue(ACT_GET, idx, $urandom_range(4096));
      end else if (pick < 78) begin
         if (flavor < 40) begin
            issue(ACT_UPDATE, idx, $urandom_range(old));
         end else if (flavor < 85) begin
            issue(ACT_UPDATE, idx, old + $urandom_range(200, 1));
         end else begin
            issue(ACT_UPDATE, idx, $urandom_range(4096));
         end
      end else if (pick < 92) begin
         issue(ACT_DELETE, idx, $urandom_range(4096));
      end else if (pick < 96) begin
         // arbitrary slot, usually beyond the directory
         case (flavor % 3)
            0:       issue(ACT_DELETE, $urandom_range(1023), $urandom_range(4096));
            1:       issue(ACT_UPDATE, $urandom_range(1023), $urandom_range(4096));
            default: issue(ACT_GET, $urandom_range(1023), $urandom_range(4096));
         endcase
      end else if (pick < 98) begin
         issue(ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)),
               $urandom_range(1023), $urandom_range(4096));
      end else begin
         issue(ACT_CLEAR, $urandom_range(1023), $urandom_range(4096));
      end
   endtask

   // A phase is a series of short page lifetimes, each opened by a clear; deep mode puts a long one first.
   task automatic run_phase(input int items, input bit deep);
      int left;
      int len;
      left = items;
      if (deep) begin
         issue(ACT_CLEAR, 0, 0);
         repeat (700) random_item(1'b1);
      end
      while (left > 0) begin
         len = $urandom_range(90, 15);
         issue(ACT_CLEAR, $urandom_range(1023), $urandom_range(4096));
         repeat (len) random_item(1'b0);
         left -= len + 1;
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_payload    <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      sender_idle_pct = 37;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_page_number($urandom);

      // empty page: every slot access is out of range
      issue(ACT_GET, 0, 0);
      issue(ACT_DELETE, 1023, 4096);
      issue(ACT_UPDATE, 0, 10);
      // zero-length insert is born a tombstone
      issue(ACT_INSERT, 0, 0);
      issue(ACT_GET, 0, 0);
      issue(ACT_DELETE, 0, 0);
      issue(ACT_UPDATE, 0, 5);
      // live record: get, shrink, same size, grow by moving
      issue(ACT_INSERT, 1023, 100);
      issue(ACT_GET, 1, 0);
      issue(ACT_UPDATE, 1, 50);
      issue(ACT_UPDATE, 1, 50);
      issue(ACT_UPDATE, 1, 200);
      // update to zero deletes
      issue(ACT_INSERT, 0, 30);
      issue(ACT_UPDATE, 2, 0);
      issue(ACT_GET, 2, 0);
      issue(ACT_DELETE, 1, 0);
      issue(ACT_GET, 1, 0);
      // largest size never fits next to the header
      issue(ACT_INSERT, 0, 4096);
      // grow that takes exactly all free space, then nothing fits
      issue(ACT_INSERT, 0, 10);
      issue(ACT_UPDATE, 3, directory.free_left());
      issue(ACT_INSERT, 0, 0);
      issue(ACT_CLEAR, 0, 0);
      issue(ACT_SPARE_LO, 1023, 4096);
      issue(ACT_SPARE_HI, 0, 0);
      // fill a fresh page to the last byte in one record
      issue(ACT_INSERT, 512, directory.free_left() - SLOT_BYTES);

      run_phase(300, 1'b0);

      write_page_number('1);
      sender_idle_pct = 79;
      run_phase(250, 1'b0);

      write_page_number('0);
      sender_idle_pct = 0;
      run_phase(100, 1'b1);

      // drain, then wait with start low to catch stray strobes
      start <= 1'b0;
      while (directory.awaited.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (directory.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
